### rtl/swefd_pkg.sv
// shared types and constants for the single-wire edge frame decoder
// no dependencies

package swefd_pkg;

   localparam int REQ_DW     = 40;
   localparam int CSR_AW     = 5;
   localparam int CSR_DW     = 32;
   localparam int CFG_W      = 8;
   localparam int TIME_W     = 32;
   localparam int RSP_UW     = 4;

   typedef enum logic [2:0] {
      PH_WAIT      = 3'd0,
      PH_RESP_LOW  = 3'd1,
      PH_RESP_HIGH = 3'd2,
      PH_DATA      = 3'd3,
      PH_GAP       = 3'd4,
      PH_ERROR     = 3'd5
   } phase_type;

   typedef enum logic [2:0] {
      REG_RESP_LOW_MIN  = 3'd0,
      REG_RESP_HIGH_MIN = 3'd1,
      REG_RESP_MAX      = 3'd2,
      REG_BIT0_MIN      = 3'd3,
      REG_BIT_SPLIT     = 3'd4,
      REG_BIT1_MAX      = 3'd5,
      REG_GAP_MIN       = 3'd6,
      REG_GAP_MAX       = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [CFG_W-1:0] resp_low_min_us;
      logic [CFG_W-1:0] resp_high_min_us;
      logic [CFG_W-1:0] resp_max_us;
      logic [CFG_W-1:0] bit0_min_us;
      logic [CFG_W-1:0] bit_split_us;
      logic [CFG_W-1:0] bit1_max_us;
      logic [CFG_W-1:0] gap_min_us;
      logic [CFG_W-1:0] gap_max_us;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      resp_low_min_us:  8'd65,
      resp_high_min_us: 8'd70,
      resp_max_us:      8'd90,
      bit0_min_us:      8'd20,
      bit_split_us:     8'd30,
      bit1_max_us:      8'd80,
      gap_min_us:       8'd20,
      gap_max_us:       8'd60
   };

endpackage

### rtl/swefd_csr.sv
// configuration register bank with apb-style access
// depends on swefd_pkg

module swefd_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [swefd_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [swefd_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [swefd_pkg::CSR_DW-1:0] csr_prdata,
   output logic                        csr_pready,
   output swefd_pkg::cfg_type          cfg_o
);
   import swefd_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          wr_en;
   logic [CFG_W-1:0] wdata;
   logic [CFG_W-1:0] rdata;

   assign index      = reg_index_type'(csr_paddr[CSR_AW-1:2]);
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign wdata      = csr_pwdata[CFG_W-1:0];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            REG_RESP_LOW_MIN:  cfg_in.resp_low_min_us  = wdata;
            REG_RESP_HIGH_MIN: cfg_in.resp_high_min_us = wdata;
            REG_RESP_MAX:      cfg_in.resp_max_us      = wdata;
            REG_BIT0_MIN:      cfg_in.bit0_min_us      = wdata;
            REG_BIT_SPLIT:     cfg_in.bit_split_us     = wdata;
            REG_BIT1_MAX:      cfg_in.bit1_max_us      = wdata;
            REG_GAP_MIN:       cfg_in.gap_min_us       = wdata;
            REG_GAP_MAX:       cfg_in.gap_max_us       = wdata;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_RESP_LOW_MIN:  rdata = cfg_ff.resp_low_min_us;
         REG_RESP_HIGH_MIN: rdata = cfg_ff.resp_high_min_us;
         REG_RESP_MAX:      rdata = cfg_ff.resp_max_us;
         REG_BIT0_MIN:      rdata = cfg_ff.bit0_min_us;
         REG_BIT_SPLIT:     rdata = cfg_ff.bit_split_us;
         REG_BIT1_MAX:      rdata = cfg_ff.bit1_max_us;
         REG_GAP_MIN:       rdata = cfg_ff.gap_min_us;
         REG_GAP_MAX:       rdata = cfg_ff.gap_max_us;
         default:           rdata = '0;
      endcase
   end

   assign csr_prdata = CSR_DW'(rdata);
   assign cfg_o      = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### rtl/swefd_core.sv
// decoder state machine, edge timing checks and frame shift register
// depends on swefd_pkg

module swefd_core #(
   parameter int FRAME_BITS = 40,
   localparam int CNT_W = $clog2(FRAME_BITS + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step_i,
   input  logic                          level_i,
   input  logic [swefd_pkg::TIME_W-1:0]  time_i,
   input  swefd_pkg::cfg_type            cfg_i,
   output swefd_pkg::phase_type          phase_o,
   output logic                          done_o,
   output logic [CNT_W-1:0]              count_o,
   output logic [FRAME_BITS-1:0]         frame_o
);
   import swefd_pkg::*;

   phase_type             phase_ff, phase_in;
   logic [TIME_W-1:0]     last_ff, last_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [FRAME_BITS-1:0] frame_ff, frame_in;
   logic [TIME_W-1:0]     dt;
   logic [CNT_W-1:0]      count_inc;
   logic                  done;
   logic                  resp_low_ok, resp_high_ok, gap_ok, bit_zero, bit_one;

   function automatic logic in_window(logic [TIME_W-1:0] t, logic [CFG_W-1:0] lo,
                                      logic [CFG_W-1:0] hi);
      return (t >= TIME_W'(lo)) && (t <= TIME_W'(hi));
   endfunction

   assign dt           = time_i - last_ff;
   assign count_inc    = count_ff + 1'b1;
   assign resp_low_ok  = in_window(dt, cfg_i.resp_low_min_us, cfg_i.resp_max_us);
   assign resp_high_ok = in_window(dt, cfg_i.resp_high_min_us, cfg_i.resp_max_us);
   assign gap_ok       = in_window(dt, cfg_i.gap_min_us, cfg_i.gap_max_us);
   assign bit_zero     = in_window(dt, cfg_i.bit0_min_us, cfg_i.bit_split_us);
   assign bit_one      = (dt > TIME_W'(cfg_i.bit_split_us)) &&
                         (dt <= TIME_W'(cfg_i.bit1_max_us));

   always_comb begin
      phase_in = phase_ff;
      last_in  = last_ff;
      count_in = count_ff;
      frame_in = frame_ff;
      done     = 1'b0;
      if (step_i) begin
         unique case (phase_ff)
            PH_WAIT: begin
               if (level_i) begin
                  phase_in = PH_ERROR;
               end else begin
                  count_in = '0;
                  frame_in = '0;
                  last_in  = time_i;
                  phase_in = PH_RESP_LOW;
               end
            end
            PH_RESP_LOW: begin
               if (level_i && resp_low_ok) begin
                  last_in  = time_i;
                  phase_in = PH_RESP_HIGH;
               end else begin
                  phase_in = PH_ERROR;
               end
            end
            PH_RESP_HIGH: begin
               if (!level_i && resp_high_ok) begin
                  last_in  = time_i;
                  phase_in = PH_DATA;
               end else begin
                  phase_in = PH_ERROR;
               end
            end
            PH_DATA: begin
               if (!level_i || !(bit_zero || bit_one)) begin
                  phase_in = PH_ERROR;
               end else begin
                  // zero takes priority on the split boundary
                  frame_in = {frame_ff[FRAME_BITS-2:0], !bit_zero};
                  count_in = count_inc;
                  last_in  = time_i;
                  if (count_inc == CNT_W'(FRAME_BITS)) begin
                     phase_in = PH_WAIT;
                     done     = 1'b1;
                  end else begin
                     phase_in = PH_GAP;
                  end
               end
            end
            PH_GAP: begin
               if (!level_i && gap_ok) begin
                  last_in  = time_i;
                  phase_in = PH_DATA;
               end else begin
                  phase_in = PH_ERROR;
               end
            end
            default: phase_in = PH_ERROR;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WAIT;
         last_ff  <= '0;
         count_ff <= '0;
         frame_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         last_ff  <= last_in;
         count_ff <= count_in;
         frame_ff <= frame_in;
      end
   end

   assign phase_o = phase_in;
   assign done_o  = done;
   assign count_o = count_in;
   assign frame_o = frame_in;

endmodule

### rtl/single_wire_edge_frame_decoder.sv
// top level of the single-wire edge frame decoder
// depends on swefd_pkg, swefd_csr and swefd_core
// usage
//   req channel: one request per line edge; req_tdata holds the new line level
//   and the microsecond timestamp of the edge. rsp channel: exactly one result
//   per request, in order, showing the decoder state after that edge. rsp_tlast
//   marks the edge that completed the last bit of a frame; rsp_tuser carries
//   the phase and the error flag, rsp_tdata the bit count and the frame bits.
//   csr port: eight 8-bit timing windows at byte addresses 0, 4, ... 28, to be
//   written only while no request is in flight.
// pipeline and throughput
//   a request goes into an input register and, once the result register is
//   free, is decoded from there into the result register. one request per
//   cycle is sustained while rsp_tready stays high; the step is one subtract
//   and a few compares.
// reset: synchronous; clears both channel valid flags, the decoder to the wait
//   phase with empty frame, and the windows to their defaults.
// stall: a held result keeps its value; the input register keeps taking
//   requests until it too is full, then req_tready drops.

module single_wire_edge_frame_decoder #(
   parameter int FRAME_BITS = 40,
   localparam int CNT_W  = $clog2(FRAME_BITS + 1),
   localparam int RSP_DW = ((CNT_W + FRAME_BITS + 7) / 8) * 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [swefd_pkg::REQ_DW-1:0]  req_tdata,   // line_level, time_us
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [RSP_DW-1:0]             rsp_tdata,   // bits_received, frame_bits
   output logic [swefd_pkg::RSP_UW-1:0]  rsp_tuser,   // phase, error_flag
   output logic                          rsp_tlast,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [swefd_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [swefd_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [swefd_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                          csr_pready
);
   import swefd_pkg::*;

   cfg_type               cfg;
   logic                  in_valid_ff, in_valid_in;
   logic                  in_level_ff;
   logic [TIME_W-1:0]     in_time_ff;
   logic                  out_valid_ff, out_valid_in;
   phase_type             out_phase_ff;
   logic                  out_done_ff;
   logic [CNT_W-1:0]      out_count_ff;
   logic [FRAME_BITS-1:0] out_frame_ff;
   logic                  out_free, step, req_take;
   phase_type             core_phase;
   logic                  core_done;
   logic [CNT_W-1:0]      core_count;
   logic [FRAME_BITS-1:0] core_frame;

   swefd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg_o       (cfg)
   );

   swefd_core #(.FRAME_BITS(FRAME_BITS)) u_core (
      .clock   (clock),
      .reset   (reset),
      .step_i  (step),
      .level_i (in_level_ff),
      .time_i  (in_time_ff),
      .cfg_i   (cfg),
      .phase_o (core_phase),
      .done_o  (core_done),
      .count_o (core_count),
      .frame_o (core_frame)
   );

   assign out_free     = !out_valid_ff || rsp_tready;
   assign step         = in_valid_ff && out_free;
   assign req_tready   = !in_valid_ff || out_free;
   assign req_take     = req_tvalid && req_tready;
   assign in_valid_in  = req_take || (in_valid_ff && !out_free);
   assign out_valid_in = step || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_level_ff <= req_tdata[0];
         in_time_ff  <= req_tdata[TIME_W:1];
      end
      if (step) begin
         out_phase_ff <= core_phase;
         out_done_ff  <= core_done;
         out_count_ff <= core_count;
         out_frame_ff <= core_frame;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_DW'({out_frame_ff, out_count_ff});
   assign rsp_tuser  = {out_phase_ff == PH_ERROR, out_phase_ff};
   assign rsp_tlast  = out_done_ff;

endmodule

### rtl/swefd_checker.sv
// port-level checks on the result channel of the decoder
// depends on swefd_pkg; bound to single_wire_edge_frame_decoder

module swefd_checker #(
   parameter int FRAME_BITS = 40,
   localparam int CNT_W  = $clog2(FRAME_BITS + 1),
   localparam int RSP_DW = ((CNT_W + FRAME_BITS + 7) / 8) * 8
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [RSP_DW-1:0]             rsp_tdata,
   input logic [swefd_pkg::RSP_UW-1:0]  rsp_tuser,
   input logic                          rsp_tlast
);
   import swefd_pkg::*;

   logic [2:0]       phase;
   logic [CNT_W-1:0] count;

   assign phase = rsp_tuser[2:0];
   assign count = rsp_tdata[CNT_W-1:0];

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   a_error_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser[3] == (phase == PH_ERROR)))
      else $error("error flag disagrees with phase");

   a_frame_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> phase == PH_WAIT && count == CNT_W'(FRAME_BITS))
      else $error("frame end without full frame");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> count <= CNT_W'(FRAME_BITS))
      else $error("bit count beyond frame length");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result offered right after reset");

endmodule

bind single_wire_edge_frame_decoder swefd_checker #(.FRAME_BITS(FRAME_BITS)) u_swefd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
